// ===== rtl/ults_pkg.sv =====
// Shared constants and types for the unit lower triangular solver.
`timescale 1ns / 1ps

package ults_pkg;

  // Largest system size and fixed-point format.
  localparam int MAX_SIZE  = 256;
  localparam int FRAC_BITS = 16;

  // Field and datapath widths.
  localparam int VAL_W     = 32;
  localparam int ROW_IDX_W = 8;
  localparam int ADDR_W    = $clog2(MAX_SIZE);
  localparam int ACC_W     = 2 * VAL_W;
  localparam int SCALE_W   = 42;
  localparam int DIFF_W    = SCALE_W + 1;

  // Limits applied to the scaled accumulator.
  localparam logic signed [ACC_W-1:0] SCALE_MAX = 64'sh0000_0100_0000_0000;
  localparam logic signed [ACC_W-1:0] SCALE_MIN = -SCALE_MAX;

  // Saturation limits of the wide accumulator and of a solution element.
  localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_NEG_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Read request to the solution store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ults_rd_t;

  // Write request to the solution store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } ults_wr_t;

endpackage

// ===== rtl/ults_if.sv =====
// Valid/ready channel interfaces for the solver input items and results.
`timescale 1ns / 1ps

interface ults_item_if import ults_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    new_system;

  modport source (output valid, output value, output new_system, input ready);
  modport sink   (input valid, input value, input new_system, output ready);
endinterface

interface ults_result_if import ults_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] x_value;
  logic [ROW_IDX_W-1:0]    row_index;
  logic                    saturated;

  modport source (output valid, output x_value, output row_index, output saturated,
                  input ready);
  modport sink   (input valid, input x_value, input row_index, input saturated,
                  output ready);
endinterface

// ===== rtl/ults_store.sv =====
// Solution store: one write port, one registered read port with write-first forwarding.
`timescale 1ns / 1ps

module ults_store import ults_pkg::*; (
  input  logic             clk_i,
  input  ults_rd_t         rd_i,
  input  ults_wr_t         wr_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [MAX_SIZE];
  logic [VAL_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port; a read that meets a write to the same entry returns the new data.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      if (wr_i.en && (wr_i.addr == rd_i.addr)) begin
        rdata_q <= wr_i.data;
      end else begin
        rdata_q <= mem[rd_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/unit_lower_triangular_solve.sv =====
// Top level of the forward substitution solver for unit lower triangular systems.
`timescale 1ns / 1ps
// A right-hand side item accepted at the input passes stages one, two and three and then
// the output register. Throughput: one item per cycle while the output is not stalled; an
// L entry whose solution element is still in the two stages after acceptance waits for it
// (short rows only) until it reaches stage three, whose store write is forwarded to the read.
// Reset clears the row and column counters, the accumulator and all valid flags;
// the solution store is not cleared and needs no sweep.

module unit_lower_triangular_solve import ults_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ults_item_if.sink     item_i,
  ults_result_if.source result_o
);

  // Input stage signals.
  logic [ADDR_W-1:0] row_q, col_q, row_eff, col_eff;
  logic              is_entry, first, hazard, accept, en;

  // Pipeline registers.
  logic                      s1_valid_q, s1_is_b_q, s1_first_q;
  logic signed [VAL_W-1:0]   s1_val_q;
  logic [ADDR_W-1:0]         s1_row_q;
  logic                      s2_valid_q, s2_is_b_q, s2_first_q;
  logic signed [VAL_W-1:0]   s2_val_q;
  logic [ADDR_W-1:0]         s2_row_q;
  logic signed [ACC_W-1:0]   s2_prod_q;
  logic                      s3_valid_q;
  logic signed [VAL_W-1:0]   s3_val_q;
  logic [ADDR_W-1:0]         s3_row_q;
  logic signed [SCALE_W-1:0] s3_scaled_q;
  logic signed [ACC_W-1:0]   acc_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_x_q;
  logic [ROW_IDX_W-1:0]    out_row_q;
  logic                    out_sat_q;

  // Datapath signals.
  ults_rd_t                  rd;
  ults_wr_t                  wr;
  logic [VAL_W-1:0]          rdata;
  logic signed [ACC_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]   acc_base, acc_d, acc_shift, acc_clamp;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [SCALE_W-1:0] scaled_d;
  logic signed [DIFF_W-1:0]  diff;
  logic                      sat_d;
  logic [VAL_W-1:0]          x_d;

  // The whole pipe holds only when a result must enter a full output register.
  assign en = !(s3_valid_q && out_valid_q && !result_o.ready);

  // Row and column tracking at the input; a new system restarts at row zero.
  always_comb begin
    row_eff  = item_i.new_system ? '0 : row_q;
    col_eff  = item_i.new_system ? '0 : col_q;
    is_entry = (col_eff < row_eff);
    first    = (col_eff == '0);
    hazard   = is_entry &&
               ((s1_valid_q && s1_is_b_q && (s1_row_q == col_eff)) ||
                (s2_valid_q && s2_is_b_q && (s2_row_q == col_eff)));
  end

  assign item_i.ready = en && !hazard;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (is_entry) begin
        row_q <= row_eff;
        col_q <= col_eff + ADDR_W'(1);
      end else begin
        row_q <= (row_eff == ADDR_W'(MAX_SIZE - 1)) ? '0 : row_eff + ADDR_W'(1);
        col_q <= '0;
      end
    end
  end

  // Solution store: read the column's element, write each finished solution.
  assign rd.en   = en;
  assign rd.addr = col_eff;
  assign wr.en   = en && s3_valid_q;
  assign wr.addr = s3_row_q;
  assign wr.data = x_d;

  ults_store u_store (
    .clk_i   (clk_i),
    .rd_i    (rd),
    .wr_i    (wr),
    .rdata_o (rdata)
  );

  // Stage one: item registered while the store read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_is_b_q  <= !is_entry;
      s1_first_q <= first;
      s1_val_q   <= item_i.value;
      s1_row_q   <= row_eff;
    end
  end

  // Stage two: exact product of the entry and the stored solution element.
  assign prod_d = s1_val_q * $signed(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_is_b_q  <= s1_is_b_q;
      s2_first_q <= s1_first_q;
      s2_val_q   <= s1_val_q;
      s2_row_q   <= s1_row_q;
      s2_prod_q  <= prod_d;
    end
  end

  // Saturating accumulate, and the rounded scale-down for a right-hand side.
  always_comb begin
    acc_base = s2_first_q ? '0 : acc_q;
    acc_sum  = {acc_base[ACC_W-1], acc_base} + {s2_prod_q[ACC_W-1], s2_prod_q};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_d = acc_sum[ACC_W] ? $signed(ACC_NEG_MIN) : $signed(ACC_POS_MAX);
    end else begin
      acc_d = acc_sum[ACC_W-1:0];
    end
    acc_shift = acc_base >>> FRAC_BITS;
    if (acc_shift > SCALE_MAX) begin
      acc_clamp = SCALE_MAX;
    end else if (acc_shift < SCALE_MIN) begin
      acc_clamp = SCALE_MIN;
    end else begin
      acc_clamp = acc_shift;
    end
    scaled_d = acc_clamp[SCALE_W-1:0] + SCALE_W'(acc_base[FRAC_BITS-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en && s2_valid_q && !s2_is_b_q) begin
      acc_q <= acc_d;
    end
  end

  // Stage three: right-hand side items only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q && s2_is_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_val_q    <= s2_val_q;
      s3_row_q    <= s2_row_q;
      s3_scaled_q <= scaled_d;
    end
  end

  // Subtract from b and clip to the 32-bit range.
  always_comb begin
    diff  = DIFF_W'(s3_val_q) - DIFF_W'(s3_scaled_q);
    sat_d = !((&diff[DIFF_W-1:VAL_W-1]) || !(|diff[DIFF_W-1:VAL_W-1]));
    if (sat_d) begin
      x_d = diff[DIFF_W-1] ? VAL_NEG_MIN : VAL_POS_MAX;
    end else begin
      x_d = diff[VAL_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && s3_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_valid_q) begin
      out_x_q   <= x_d;
      out_row_q <= ROW_IDX_W'(s3_row_q);
      out_sat_q <= sat_d;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.x_value   = out_x_q;
  assign result_o.row_index = out_row_q;
  assign result_o.saturated = out_sat_q;

  // The column never runs past the row it belongs to.
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q <= row_q)
    else $error("column counter ran past the row counter");

  // A right-hand side leaving stage two reaches stage three on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s2_valid_q && s2_is_b_q |=> s3_valid_q)
    else $error("right-hand side item lost between stages");

  // A clipped result sits at one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.saturated |->
      (out_x_q == $signed(VAL_POS_MAX)) || (out_x_q == $signed(VAL_NEG_MIN)))
    else $error("saturated result not at a range limit");

endmodule
